// ===== src/sstg_pkg.sv =====
package sstg_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] REG_PHASE_STEP     = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_GAIN           = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_CHANNEL_SELECT = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_PHASE_REVERSE  = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_EIGHT_BIT_MODE = 3'd4;

  // Channel selector codes.
  localparam logic [1:0] CH_BOTH  = 2'd0;
  localparam logic [1:0] CH_LEFT  = 2'd1;
  localparam logic [1:0] CH_RIGHT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [31:0] PHASE_STEP_RST = 32'd97391549;
  localparam logic [14:0] GAIN_RST       = 15'd32767;

  // Sample range constants.
  localparam logic [14:0] AMP_MAX  = 15'd32767;
  localparam logic [6:0]  MAG8_MAX = 7'd127;
  localparam logic [15:0] OFFSET8  = 16'd128;

  // Fixed point constants for the sine series (Q30).
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  typedef logic [14:0] amp_t;

  // Sine magnitude (0..32767) of point m of a quarter wave of 2^qb points.
  // Evaluated at elaboration only: quarter-wave angle, then a Horner form
  // of the degree-11 Taylor series in Q30, then rounding to 15 bits.
  function automatic amp_t sine_amp(input logic [63:0] m, input int unsigned qb);
    logic [63:0] u;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] r;
    logic [63:0] s;
    logic [63:0] a;
    u  = m << (30 - qb);
    x  = (u * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    r  = ONE_Q30 - x2 / 110;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 72;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 42;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 20;
    r  = ONE_Q30 - ((x2 * r) >> 30) / 6;
    s  = (x * r) >> 30;
    a  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (a > 64'd32767) begin
      a = 64'd32767;
    end
    return a[14:0];
  endfunction

endpackage

// ===== src/stereo_sine_tone_generator_unit.sv =====
// Channel      | Direction | Payload (lowest bit first)
// -------------+-----------+-----------------------------------------------
// s_axis       | in        | tdata[0] restart, tdata[7:1] zero
// m_axis       | out       | tdata[15:0] left_sample, tdata[31:16] right_sample
// cfg          | in        | cfg_addr_i register index, cfg_wdata_i value
//
// Four register stages: phase/index, table read and gain multiply, first
// divide by 32767, sample formatting. One word is accepted every cycle while
// the output is taken. Reset clears the phase accumulator and stage valids,
// and loads the configuration registers with their reset values.
// A stalled output holds only the stages that are full; empty stages behind
// it keep taking words, so the input stalls only when all four are full.
module stereo_sine_tone_generator_unit
  import sstg_pkg::*;
#(
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned PHASE_BITS       = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,   // [0] restart
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o,   // [15:0] left, [31:16] right
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i
);

  // Table geometry: index is the top IdxBits of the phase, folded to a quarter.
  localparam int unsigned IdxBits = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int unsigned QBits   = IdxBits - 2;
  localparam int unsigned Quarter = 1 << QBits;

  typedef amp_t rom_t [Quarter];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int unsigned i = 0; i < Quarter; i++) begin
      rom[i] = sine_amp(64'(i), QBits);
    end
    return rom;
  endfunction

  localparam rom_t SineRom  = build_rom();
  localparam amp_t SinePeak = sine_amp(64'(Quarter), QBits);

  // Configuration registers.
  logic [31:0] phase_step_q;
  logic [14:0] gain_q;
  logic [1:0]  chan_sel_q;
  logic        phase_rev_q;
  logic        eight_bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= PHASE_STEP_RST;
      gain_q       <= GAIN_RST;
      chan_sel_q   <= CH_BOTH;
      phase_rev_q  <= 1'b0;
      eight_bit_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_PHASE_STEP:     phase_step_q <= cfg_wdata_i;
        REG_GAIN:           gain_q       <= cfg_wdata_i[14:0];
        REG_CHANNEL_SELECT: chan_sel_q   <= cfg_wdata_i[1:0];
        REG_PHASE_REVERSE:  phase_rev_q  <= cfg_wdata_i[0];
        REG_EIGHT_BIT_MODE: eight_bit_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Stage valids and the ready chain running back from the output.
  logic va_q, vb_q, vc_q, vd_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  logic s_fire;

  assign rdy_d  = !vd_q || m_axis_tready_i;
  assign rdy_c  = !vc_q || rdy_d;
  assign rdy_b  = !vb_q || rdy_c;
  assign rdy_a  = !va_q || rdy_b;
  assign s_fire = s_axis_tvalid_i && rdy_a;

  assign s_axis_tready_o = rdy_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= s_axis_tvalid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
      if (rdy_d) vd_q <= vc_q;
    end
  end

  // Stage A: phase accumulator and quarter-wave folding of the table index.
  logic [PHASE_BITS-1:0] acc_q, acc_d;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] step_w;
  logic [IdxBits-1:0]    idx;
  logic [QBits-1:0]      rem;
  logic [QBits:0]        fold_d, fold_q;
  logic [1:0]            quad_q;

  assign step_w    = PHASE_BITS'(phase_step_q);
  assign phase_cur = s_axis_tdata_i[0] ? '0 : acc_q;
  assign acc_d     = phase_cur + step_w;
  assign idx       = phase_cur[PHASE_BITS-1 -: IdxBits];
  assign rem       = idx[QBits-1:0];
  assign fold_d    = idx[QBits] ? ((QBits+1)'(Quarter) - {1'b0, rem}) : {1'b0, rem};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (s_fire) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      fold_q <= fold_d;
      quad_q <= idx[IdxBits-1 -: 2];
    end
  end

  // Stage B: table read, sign of each channel and the gain product.
  amp_t        amp;
  logic        neg_raw;
  logic [29:0] prod_q;
  logic        neg_l_b_q, neg_r_b_q;

  assign amp     = fold_q[QBits] ? SinePeak : SineRom[fold_q[QBits-1:0]];
  assign neg_raw = quad_q[1] && (amp != '0);

  always_ff @(posedge clk_i) begin
    if (va_q && rdy_b) begin
      prod_q    <= 30'(amp) * 30'(gain_q);
      neg_l_b_q <= neg_raw;
      neg_r_b_q <= (phase_rev_q ? !neg_raw : neg_raw) && (amp != '0);
    end
  end

  // Stage C: product divided by 32767, quotient and remainder.
  logic [30:0] div_sum;
  logic [14:0] q1_d, q1_q, r1_q;
  logic [29:0] r1_full;
  logic        neg_l_c_q, neg_r_c_q;

  assign div_sum = 31'(prod_q) + 31'(prod_q >> 15) + 31'd1;
  assign q1_d    = div_sum[29:15];
  assign r1_full = prod_q - {q1_d, 15'd0} + 30'(q1_d);

  always_ff @(posedge clk_i) begin
    if (vb_q && rdy_c) begin
      q1_q      <= q1_d;
      r1_q      <= r1_full[14:0];
      neg_l_c_q <= neg_l_b_q;
      neg_r_c_q <= neg_r_b_q;
    end
  end

  // Stage D: 8-bit magnitude by two more divides by 32767, then the samples.
  logic [21:0] r127;
  logic [22:0] u_sum;
  logic [6:0]  u8;
  logic [21:0] t8;
  logic [22:0] t_sum;
  logic [7:0]  mag8_raw;
  logic [6:0]  mag8;
  logic        left_on, right_on;
  logic [15:0] left_d, right_d;
  logic [15:0] left_q, right_q;

  assign r127     = {r1_q, 7'd0} - 22'(r1_q);
  assign u_sum    = 23'(r127) + 23'(r127 >> 15) + 23'd1;
  assign u8       = u_sum[21:15];
  assign t8       = {q1_q, 7'd0} - 22'(q1_q) + 22'(u8);
  assign t_sum    = 23'(t8) + 23'(t8 >> 15) + 23'd1;
  assign mag8_raw = t_sum[22:15];
  assign mag8     = (mag8_raw > 8'(MAG8_MAX)) ? MAG8_MAX : mag8_raw[6:0];

  assign left_on  = (chan_sel_q == CH_BOTH) || (chan_sel_q == CH_LEFT);
  assign right_on = (chan_sel_q == CH_BOTH) || (chan_sel_q == CH_RIGHT);

  function automatic logic [15:0] fmt(input logic [14:0] mag, input logic [6:0] m8,
                                      input logic neg, input logic on,
                                      input logic eight);
    logic [15:0] v;
    if (eight) begin
      if (!on) v = OFFSET8;
      else if (neg) v = OFFSET8 - 16'(m8);
      else v = OFFSET8 + 16'(m8);
    end else begin
      if (!on) v = '0;
      else if (neg) v = 16'd0 - {1'b0, mag};
      else v = {1'b0, mag};
    end
    return v;
  endfunction

  assign left_d  = fmt(q1_q, mag8, neg_l_c_q, left_on, eight_bit_q);
  assign right_d = fmt(q1_q, mag8, neg_r_c_q, right_on, eight_bit_q);

  always_ff @(posedge clk_i) begin
    if (vc_q && rdy_d) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign m_axis_tvalid_o = vd_q;
  assign m_axis_tdata_o  = {right_q, left_q};

  // A restart word leaves the accumulator holding exactly one step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tdata_i[0] |=> acc_q == $past(step_w))
    else $error("phase not cleared by restart");

  // Quotient and remainder of stage C reproduce the product they came from.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vb_q && rdy_c |=> vc_q && (r1_q < AMP_MAX) &&
      (32'(q1_q) * 32'd32767 + 32'(r1_q) == 32'($past(prod_q))))
    else $error("divide by 32767 wrong");

  // The input stalls only when every stage holds a word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> va_q && vb_q && vc_q && vd_q)
    else $error("input stalled with an empty stage");

  // The 8-bit magnitude never needs its clamp.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc_q |-> mag8_raw <= 8'(MAG8_MAX))
    else $error("8-bit magnitude out of range");

endmodule
